// ===== design/spd_pkg.sv =====
// Shared types, register and operation codes for the stereo ping-pong delay.
package spd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DELAY_W    = 25;
  localparam int FB_W       = 16;
  localparam int MIX_W      = 17;
  localparam int OP_W       = 3;

  localparam logic [FB_W-1:0]  FB_MAX  = 16'd64880;
  localparam logic [MIX_W-1:0] Q16_ONE = 17'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO   = 3'd3;

  // multiply-accumulate operations, issued in this order
  localparam logic [OP_W-1:0] OP_TAPL = 3'd0;
  localparam logic [OP_W-1:0] OP_TAPR = 3'd1;
  localparam logic [OP_W-1:0] OP_FBL  = 3'd2;
  localparam logic [OP_W-1:0] OP_FBR  = 3'd3;
  localparam logic [OP_W-1:0] OP_OUTL = 3'd4;
  localparam logic [OP_W-1:0] OP_OUTR = 3'd5;
  localparam logic [OP_W-1:0] OP_WRL  = 3'd6;
  localparam logic [OP_W-1:0] OP_WRR  = 3'd7;
  localparam logic [OP_W-1:0] OP_FIRST = OP_TAPL;
  localparam logic [OP_W-1:0] OP_LAST  = OP_WRR;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } spd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } spd_out_t;

  typedef struct packed {
    logic            load_in;
    logic            rd_en;
    logic            rd_i1;
    logic            cap_a;
    logic            cap_b;
    logic            mul_en;
    logic [OP_W-1:0] mul_op;
    logic            line_wr;
    logic            out_load;
  } spd_cmd_t;

endpackage

// ===== design/stereo_pingpong_delay.sv =====
// Stereo ping-pong delay with interpolated fractional taps, top level.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) takes one stereo
//    Q1.23 sample pair per item; output channel (out_valid_o / out_stall_i /
//    out_data_o) returns one mixed pair per item, in order.
//  - Config channel (cfg_valid_i / cfg_ready_o) writes delay, feedback, wet
//    mix and stereo amount by index; values are clamped on write. Write only
//    while the block is idle; cfg_ready_o is always high.
//  - Each item takes two reads per line on the single RAM read port, then
//    eight products through one shared multiplier, then the line write.
//    The next item is accepted once the block is back in its idle state;
//    in_stall_o is high in every other state.
//  - A finished result sits in the output register; a new item is accepted
//    while it waits. If that is still stalled when the next result is done,
//    the block holds in its wait state and stops accepting.
//  - Reset: lines read as zero until written (tracked with the write pointer
//    and a wrapped flag, no clearing pass), delay = 1 sample, gains zero.
module stereo_pingpong_delay #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  spd_pkg::spd_in_t               in_data_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output spd_pkg::spd_out_t              out_data_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  spd_pkg::spd_cmd_t cmd;

  // writes land in any cycle; caller keeps them to idle periods
  assign cfg_ready_o = 1'b1;

  spd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  spd_datapath #(.LINE_DEPTH(LINE_DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/spd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module spd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spd_datapath.sv =====
// Datapath: config registers, delay lines, tap reads and shared multiply-accumulate.
module spd_datapath #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  spd_pkg::spd_in_t                 in_data_i,
  input  spd_pkg::spd_cmd_t                cmd_i,
  output spd_pkg::spd_out_t                out_data_o
);

  localparam int SB   = spd_pkg::SAMPLE_W;
  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int CW   = (AW + 9 > 26) ? AW + 9 : 26;
  localparam int XW   = CW + 1;
  localparam int PAW  = SB + 1;
  localparam int MW   = SB + 2;
  localparam int PRW  = MW + 18;
  localparam int ACCW = SB + 21;
  localparam int DW   = spd_pkg::DELAY_W;

  localparam logic [CW-1:0]          DMIN  = CW'(256);
  localparam logic [CW-1:0]          DMAX  = CW'((LINE_DEPTH - 1) * 256);
  localparam logic [XW-1:0]          SPAN  = XW'(LINE_DEPTH * 256);
  localparam logic [AW-1:0]          LAST  = AW'(LINE_DEPTH - 1);
  localparam logic signed [ACCW-1:0] RND8  = ACCW'(128);
  localparam logic signed [ACCW-1:0] RND16 = ACCW'(32768);

  function automatic logic signed [SB-1:0] sat_s(input logic signed [ACCW-1:0] v);
    logic signed [SB-1:0] r;
    if (v[ACCW-1:SB-1] == {(ACCW-SB+1){v[ACCW-1]}}) begin
      r = v[SB-1:0];
    end else if (v[ACCW-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration registers
  logic [DW-1:0]                 delay_q, delay_d;
  logic [spd_pkg::FB_W-1:0]      fb_gain_q, fb_gain_d;
  logic [spd_pkg::MIX_W-1:0]     wet_q, wet_d;
  logic [spd_pkg::MIX_W-1:0]     stereo_q, stereo_d;
  logic [CW-1:0]                 dly_ext;
  logic [spd_pkg::FB_W-1:0]      fb_raw;
  logic [spd_pkg::MIX_W-1:0]     mix_raw;

  assign dly_ext = CW'(cfg_data_i[DW-1:0]);
  assign fb_raw  = cfg_data_i[spd_pkg::FB_W-1:0];
  assign mix_raw = cfg_data_i[spd_pkg::MIX_W-1:0];

  always_comb begin
    delay_d   = delay_q;
    fb_gain_d = fb_gain_q;
    wet_d     = wet_q;
    stereo_d  = stereo_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        spd_pkg::REG_DELAY: begin
          if (dly_ext < DMIN) begin
            delay_d = DW'(DMIN);
          end else if (dly_ext > DMAX) begin
            delay_d = DW'(DMAX);
          end else begin
            delay_d = cfg_data_i[DW-1:0];
          end
        end
        spd_pkg::REG_FEEDBACK: begin
          fb_gain_d = (fb_raw > spd_pkg::FB_MAX) ? spd_pkg::FB_MAX : fb_raw;
        end
        spd_pkg::REG_WET: begin
          wet_d = (mix_raw > spd_pkg::Q16_ONE) ? spd_pkg::Q16_ONE : mix_raw;
        end
        spd_pkg::REG_STEREO: begin
          stereo_d = (mix_raw > spd_pkg::Q16_ONE) ? spd_pkg::Q16_ONE : mix_raw;
        end
        default: begin
        end
      endcase
    end
  end

  // write pointer; wrapped_q marks that every entry has been written once
  logic [AW-1:0] wi_q, wi_d;
  logic          wrapped_q, wrapped_d;

  always_comb begin
    wi_d      = wi_q;
    wrapped_d = wrapped_q;
    if (cmd_i.line_wr) begin
      if (wi_q == LAST) begin
        wi_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wi_d = AW'(wi_q + AW'(1));
      end
    end
  end

  logic acc_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= DW'(256);
      fb_gain_q <= '0;
      wet_q     <= '0;
      stereo_q  <= '0;
      wi_q      <= '0;
      wrapped_q <= 1'b0;
      acc_v_q   <= 1'b0;
    end else begin
      delay_q   <= delay_d;
      fb_gain_q <= fb_gain_d;
      wet_q     <= wet_d;
      stereo_q  <= stereo_d;
      wi_q      <= wi_d;
      wrapped_q <= wrapped_d;
      acc_v_q   <= cmd_i.mul_en;
    end
  end

  // fractional read position
  logic [XW-1:0] pos_diff, pos;
  logic [AW-1:0] i0, i1;
  logic [7:0]    frac;
  logic          v0, v1;

  assign pos_diff = XW'({wi_q, 8'h00}) - XW'(delay_q);
  assign pos      = pos_diff[XW-1] ? (pos_diff + SPAN) : pos_diff;
  assign i0       = pos[AW+7:8];
  assign frac     = pos[7:0];
  assign i1       = (i0 == LAST) ? '0 : AW'(i0 + AW'(1));
  // entries not yet written read as zero
  assign v0       = wrapped_q || (i0 < wi_q);
  assign v1       = wrapped_q || (i1 < wi_q);

  // delay lines
  logic signed [SB-1:0] wr_l_q, wr_r_q;
  logic [SB-1:0]        l_rdata, r_rdata;
  logic [AW-1:0]        raddr;

  assign raddr = cmd_i.rd_i1 ? i1 : i0;

  spd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_left_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_wr),
    .waddr_i (wi_q),
    .wdata_i (wr_l_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (l_rdata)
  );

  spd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_right_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_wr),
    .waddr_i (wi_q),
    .wdata_i (wr_r_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (r_rdata)
  );

  // operand registers
  logic signed [SB-1:0] in_l_q, in_r_q;
  logic signed [SB-1:0] a_l_q, a_r_q, b_l_q, b_r_q;
  logic signed [SB-1:0] tap_l_q, tap_r_q, fbk_l_q, fbk_r_q, mix_l_q, mix_r_q;
  logic signed [SB-1:0] out_l_q, out_r_q;

  logic signed [PAW-1:0] par_l, par_r;
  assign par_l = PAW'(in_l_q) + PAW'(fbk_l_q);
  assign par_r = PAW'(in_r_q) + PAW'(fbk_r_q);

  // operand select for the shared multiplier
  logic signed [MW-1:0]   ma;
  logic signed [17:0]     mb;
  logic signed [ACCW-1:0] base_d, base_q;
  logic                   sh16_d, sh16_q;
  logic signed [PRW-1:0]  prod_q;
  logic [spd_pkg::OP_W-1:0] acc_op_q;

  always_comb begin
    ma     = '0;
    mb     = '0;
    base_d = '0;
    sh16_d = 1'b1;
    case (cmd_i.mul_op)
      spd_pkg::OP_TAPL: begin
        ma     = MW'(b_l_q) - MW'(a_l_q);
        mb     = $signed({10'd0, frac});
        base_d = (ACCW'(a_l_q) <<< 8) + RND8;
        sh16_d = 1'b0;
      end
      spd_pkg::OP_TAPR: begin
        ma     = MW'(b_r_q) - MW'(a_r_q);
        mb     = $signed({10'd0, frac});
        base_d = (ACCW'(a_r_q) <<< 8) + RND8;
        sh16_d = 1'b0;
      end
      spd_pkg::OP_FBL: begin
        ma     = MW'(tap_l_q);
        mb     = $signed({2'b00, fb_gain_q});
        base_d = RND16;
      end
      spd_pkg::OP_FBR: begin
        ma     = MW'(tap_r_q);
        mb     = $signed({2'b00, fb_gain_q});
        base_d = RND16;
      end
      spd_pkg::OP_OUTL: begin
        ma     = MW'(tap_l_q) - MW'(in_l_q);
        mb     = $signed({1'b0, wet_q});
        base_d = (ACCW'(in_l_q) <<< 16) + RND16;
      end
      spd_pkg::OP_OUTR: begin
        ma     = MW'(tap_r_q) - MW'(in_r_q);
        mb     = $signed({1'b0, wet_q});
        base_d = (ACCW'(in_r_q) <<< 16) + RND16;
      end
      // cross-routed sum of one side is the parallel sum of the other
      spd_pkg::OP_WRL: begin
        ma     = MW'(par_r) - MW'(par_l);
        mb     = $signed({1'b0, stereo_q});
        base_d = (ACCW'(par_l) <<< 16) + RND16;
      end
      spd_pkg::OP_WRR: begin
        ma     = MW'(par_l) - MW'(par_r);
        mb     = $signed({1'b0, stereo_q});
        base_d = (ACCW'(par_r) <<< 16) + RND16;
      end
      default: begin
      end
    endcase
  end

  // accumulate, round shift and saturate
  logic signed [ACCW-1:0] sum, shifted;
  logic signed [SB-1:0]   res;

  assign sum     = ACCW'(prod_q) + base_q;
  assign shifted = sh16_q ? (sum >>> 16) : (sum >>> 8);
  assign res     = sat_s(shifted);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_l_q <= in_data_i.in_left;
      in_r_q <= in_data_i.in_right;
    end
    if (cmd_i.cap_a) begin
      a_l_q <= v0 ? $signed(l_rdata) : '0;
      a_r_q <= v0 ? $signed(r_rdata) : '0;
    end
    if (cmd_i.cap_b) begin
      b_l_q <= v1 ? $signed(l_rdata) : '0;
      b_r_q <= v1 ? $signed(r_rdata) : '0;
    end
    if (cmd_i.mul_en) begin
      prod_q   <= ma * mb;
      base_q   <= base_d;
      sh16_q   <= sh16_d;
      acc_op_q <= cmd_i.mul_op;
    end
    if (acc_v_q) begin
      case (acc_op_q)
        spd_pkg::OP_TAPL: tap_l_q <= res;
        spd_pkg::OP_TAPR: tap_r_q <= res;
        spd_pkg::OP_FBL:  fbk_l_q <= res;
        spd_pkg::OP_FBR:  fbk_r_q <= res;
        spd_pkg::OP_OUTL: mix_l_q <= res;
        spd_pkg::OP_OUTR: mix_r_q <= res;
        spd_pkg::OP_WRL:  wr_l_q  <= res;
        spd_pkg::OP_WRR:  wr_r_q  <= res;
        default: begin
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_l_q <= mix_l_q;
      out_r_q <= mix_r_q;
    end
  end

  assign out_data_o.out_left  = out_l_q;
  assign out_data_o.out_right = out_r_q;

endmodule

// ===== design/spd_ctrl.sv =====
// Controller: handshakes and the per-item sequence of reads, products and writes.
module spd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spd_pkg::spd_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD1   = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [spd_pkg::OP_W-1:0] step_q, step_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.rd_en   = 1'b1;
          state_d       = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_i1 = 1'b1;
        cmd_o.cap_a = 1'b1;
        state_d     = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_b = 1'b1;
        step_d      = spd_pkg::OP_FIRST;
        state_d     = S_MAC;
      end
      S_MAC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = step_q;
        if (step_q == spd_pkg::OP_LAST) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + {{(spd_pkg::OP_W-1){1'b0}}, 1'b1};
        end
      end
      S_DRAIN: begin
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.line_wr = 1'b1;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= spd_pkg::OP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
